>>> rtl/mbps_pkg.sv
// masked byte pattern search: shared types and constants
// used by every module of the block; depends on nothing

package mbps_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int BYTES_W     = 64;
    localparam int COUNT_W     = 16;
    localparam int LEN_W       = 4;
    localparam int MASK_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [BYTES_W-1:0] PATTERN_RESET = '0;
    localparam logic [MASK_W-1:0]  CARE_RESET    = 8'hFF;
    localparam logic [LEN_W-1:0]   LENGTH_RESET  = 4'd1;
    localparam logic [ADDR_W-1:0]  BASE_RESET    = '0;
    localparam logic [COUNT_W-1:0] LIMIT_RESET   = 16'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES  = 3'd0,
        CFG_CARE_MASK      = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_BASE_ADDRESS   = 3'd3,
        CFG_MAX_MATCHES    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  match_address;
        logic [BYTES_W-1:0] window_bytes;
        logic [COUNT_W-1:0] match_number;
    } t_out;

    // per-cell compare setup, aligned to the cell's place in the window
    typedef struct packed {
        logic [DATA_W-1:0] pat;
        logic              care;
        logic              used;
    } t_cell_cfg;

endpackage

>>> rtl/mbps_cell.sv
// one window cell: holds a byte, passes it to the older neighbour each transaction
// and compares the byte it takes in against its aligned pattern byte; uses mbps_pkg

module mbps_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic                      i_clear,
    input  logic [7:0]                i_byte,
    input  mbps_pkg::t_cell_cfg       i_cfg,
    output logic [7:0]                o_byte,
    output logic [7:0]                o_next,
    output logic                      o_ok
);
    import mbps_pkg::*;

    logic [DATA_W-1:0] r_byte;

    // the compare sees the window as it stands after this transaction
    assign o_next = i_byte;
    assign o_byte = r_byte;
    assign o_ok   = !i_cfg.used || !i_cfg.care || (i_byte == i_cfg.pat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_clear ? '0 : i_byte;
        end
    end

endmodule

>>> rtl/mbps_out_buf.sv
// result register with one skid entry behind it
// lets the scan take a byte while a result waits; uses mbps_pkg

module mbps_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbps_pkg::t_out i_data,
    output logic           o_full,
    output logic           o_valid,
    output mbps_pkg::t_out o_data,
    input  logic           i_ready
);
    import mbps_pkg::*;

    logic r_valid;
    logic r_skid_valid;
    t_out r_data;
    t_out r_skid;
    logic take;

    assign take    = r_valid && i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_data       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid || take) begin
                r_data  <= i_data;
                r_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

endmodule

>>> rtl/masked_byte_pattern_search_top.sv
// Masked byte pattern search. Takes one memory byte per clock while the output
// skid entry is free, so a byte can follow in every cycle; a result goes to the
// output register, or to the skid entry while an earlier result waits. The byte
// window is a chain of MAX_PATTERN_BYTES cells, each comparing its byte in parallel,
// so the whole masked compare, the address add and the limit check act within the
// transaction. The configuration port is always ready; the user must write it only
// while no scan is in progress, which the block does not enforce. A byte marked last
// clears window and counters. Top level; uses mbps_pkg, mbps_cell and mbps_out_buf.

module masked_byte_pattern_search_top #(
    parameter int MAX_PATTERN_BYTES = 8,
    parameter int OFFSET_BITS       = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  mbps_pkg::t_in                          i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output mbps_pkg::t_out                         o_out
);
    import mbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    logic [BYTES_W-1:0]     r_pattern;
    logic [MASK_W-1:0]      r_care;
    logic [LEN_W-1:0]       r_length;
    logic [ADDR_W-1:0]      r_base;
    logic [COUNT_W-1:0]     r_limit;
    logic [OFFSET_BITS-1:0] r_seen;
    logic [COUNT_W-1:0]     r_found;
    logic                   r_ovf;

    logic [OFFSET_BITS-1:0] n_seen;
    logic [COUNT_W-1:0]     n_found;
    logic                   n_ovf;

    logic                   accept;
    logic                   buf_full;
    logic [LEN_W-1:0]       len_c;
    logic [LEN_W-1:0]       shift_amt;
    logic [OFFSET_BITS:0]   pos_inc;
    logic [OFFSET_BITS:0]   start;
    logic                   enable;
    logic                   report;
    logic [BYTES_W-1:0]     got;
    t_out                   res;

    t_cell_cfg              cell_cfg [MAX_PATTERN_BYTES];
    logic [DATA_W-1:0]      w_cur    [MAX_PATTERN_BYTES];
    logic [DATA_W-1:0]      w_new    [MAX_PATTERN_BYTES];
    logic [DATA_W-1:0]      w_in     [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !buf_full;
    assign accept      = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PATTERN_RESET;
            r_care    <= CARE_RESET;
            r_length  <= LENGTH_RESET;
            r_base    <= BASE_RESET;
            r_limit   <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pattern <= i_cfg_data;
                CFG_CARE_MASK:      r_care    <= i_cfg_data[MASK_W-1:0];
                CFG_PATTERN_LENGTH: r_length  <= i_cfg_data[LEN_W-1:0];
                CFG_BASE_ADDRESS:   r_base    <= i_cfg_data[ADDR_W-1:0];
                CFG_MAX_MATCHES:    r_limit   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_c     = (r_length > MAX_LEN) ? MAX_LEN : r_length;
    assign shift_amt = MAX_LEN - len_c;

    // line pattern byte j up with cell (MAX - len + j)
    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            logic [4:0] sum;
            logic [2:0] j;
            sum = 5'(k) + 5'(len_c);
            j   = 3'(sum - 5'(MAX_PATTERN_BYTES));
            cell_cfg[k].used = (sum >= 5'(MAX_PATTERN_BYTES));
            cell_cfg[k].care = r_care[j];
            cell_cfg[k].pat  = r_pattern[8*j +: 8];
        end
    end

    // the newest byte enters at the top cell and moves down one cell a transaction
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        if (k == MAX_PATTERN_BYTES - 1) begin : g_head
            assign w_in[k] = i_in.data_byte;
        end else begin : g_body
            assign w_in[k] = w_cur[k+1];
        end

        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_clear (i_in.last_byte),
            .i_byte  (w_in[k]),
            .i_cfg   (cell_cfg[k]),
            .o_byte  (w_cur[k]),
            .o_next  (w_new[k]),
            .o_ok    (cell_ok[k])
        );
    end

    // window bytes from the window start, upper unused bytes zero
    always_comb begin
        got = '0;
        for (int j = 0; j < 8; j++) begin
            logic [4:0] idx;
            idx = 5'(j) + 5'(shift_amt);
            if ((4'(j) < len_c) && (idx < 5'(MAX_PATTERN_BYTES))) begin
                got[8*j +: 8] = w_new[idx[IDX_W-1:0]];
            end
        end
    end

    assign pos_inc = {1'b0, r_seen} + (OFFSET_BITS+1)'(1);
    assign start   = pos_inc - (OFFSET_BITS+1)'(len_c);
    assign enable  = !r_ovf && (r_length != '0) && (pos_inc >= (OFFSET_BITS+1)'(len_c));
    assign report  = accept && enable && (&cell_ok)
                     && ((r_found == '0) || (r_found < r_limit));

    assign res.match_address = r_base + ADDR_W'(start);
    assign res.window_bytes  = got;
    assign res.match_number  = r_found;

    always_comb begin
        n_seen  = r_seen;
        n_found = report ? (r_found + COUNT_W'(1)) : r_found;
        n_ovf   = r_ovf;
        if (!r_ovf) begin
            if (r_seen == '1) begin
                n_ovf = 1'b1;
            end else begin
                n_seen = r_seen + OFFSET_BITS'(1);
            end
        end
        if (i_in.last_byte) begin
            n_seen  = '0;
            n_found = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_found <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_seen  <= n_seen;
            r_found <= n_found;
            r_ovf   <= n_ovf;
        end
    end

    mbps_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (report),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_ready (i_out_ready)
    );

endmodule

>>> rtl/mbps_checker.sv
// port-level checks for the masked byte pattern search top level
// uses mbps_pkg; attached to masked_byte_pattern_search_top by the bind below

module mbps_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input mbps_pkg::t_out o_out
);
    import mbps_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("results left after reset");

    // input only stalls when a result is waiting in front of the skid entry
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !i_out_ready |=> !o_in_ready && o_out_valid)
        else $error("skid entry lost without a transaction");

endmodule

bind masked_byte_pattern_search_top mbps_checker u_mbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench for masked_byte_pattern_search_top: directed and random byte scans
// against a cycle-free predictor of the masked window compare; needs mbps_pkg and the rtl

module testbench;
    import mbps_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int STALL_CYCLES  = 60;
    localparam int IDLE_PCT      = 13;

    // predicts the match reports of one scan stream and holds those still owed
    class match_predictor;
        logic [63:0] pattern;
        logic [7:0]  care;
        logic [3:0]  pat_len;
        logic [31:0] base;
        logic [15:0] match_limit;
        logic [7:0]  window [8];
        logic [23:0] offset;
        logic [15:0] found;
        logic        overflowed;
        t_out        expected_matches [$];
        int          errors;

        function new();
            pattern     = PATTERN_RESET;
            care        = CARE_RESET;
            pat_len     = LENGTH_RESET;
            base        = BASE_RESET;
            match_limit = LIMIT_RESET;
            errors      = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i]) window[i] = 8'h00;
            offset     = '0;
            found      = '0;
            overflowed = 1'b0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] value);
            case (idx)
                CFG_PATTERN_BYTES:  pattern = value;
                CFG_CARE_MASK:      care = value[7:0];
                CFG_PATTERN_LENGTH: pat_len = value[3:0];
                CFG_BASE_ADDRESS:   base = value[31:0];
                CFG_MAX_MATCHES:    match_limit = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        function void note_byte(t_in item);
            logic [3:0]  len;
            logic [7:0]  w;
            logic [63:0] grabbed;
            logic        hit;
            t_out        exp_item;
            len = (pat_len > 4'd8) ? 4'd8 : pat_len;
            for (int i = 0; i < 7; i++) window[i] = window[i + 1];
            window[7] = item.data_byte;
            if (!overflowed && len != 0 && offset + 32'd1 >= len) begin
                hit = 1'b1;
                grabbed = '0;
                for (int j = 0; j < len; j++) begin
                    w = window[8 - len + j];
                    if (care[j] && w != pattern[8*j +: 8]) hit = 1'b0;
                    grabbed[8*j +: 8] = w;
                end
                // the first hit of a scan is reported even with a zero limit
                if (hit && (found == 0 || found < match_limit)) begin
                    exp_item.match_address = base + (offset + 32'd1 - len);
                    exp_item.window_bytes  = grabbed;
                    exp_item.match_number  = found;
                    expected_matches.insert(expected_matches.size(), exp_item);
                    found = found + 16'd1;
                end
            end
            if (!overflowed) begin
                if (offset == '1) overflowed = 1'b1;
                else offset = offset + 24'd1;
            end
            if (item.last_byte) clear_scan();
        endfunction

        function void mismatch(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        endfunction

        function void check_match(t_out got);
            t_out want;
            if (expected_matches.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_matches.pop_front();
            if (got.match_address !== want.match_address)
                mismatch("match_address", 64'(want.match_address), 64'(got.match_address));
            if (got.window_bytes !== want.window_bytes)
                mismatch("window_bytes", want.window_bytes, got.window_bytes);
            if (got.match_number !== want.match_number)
                mismatch("match_number", 64'(want.match_number), 64'(got.match_number));
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in                    i_in        = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out                   o_out;

    match_predictor sb = new();
    bit no_idle;
    bit stall_request;
    int random_items;
    int quiet_cycles;

    masked_byte_pattern_search_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random idling, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_match(o_out);
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // leaves i_cfg_valid high so back-to-back writes need no toggle
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{data_byte: value, last_byte: last};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(i_in);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        // a byte with no result may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_up_phase(input bit flood);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(5))
                0: v = '0;
                1: v = '1;
                default: ;
            endcase
            write_reg(CFG_PATTERN_BYTES, v);
        end
        v = {$urandom, $urandom};
        if (flood || $urandom_range(99) < 60) begin
            case ($urandom_range(7))
                0: v[7:0] = 8'h00;
                1, 2: v[7:0] = 8'hFF;
                default: ;
            endcase
            if (flood) v[7:0] = 8'h00;
            write_reg(CFG_CARE_MASK, v);
        end
        v = {$urandom, $urandom};
        if (flood || $urandom_range(99) < 60) begin
            case ($urandom_range(9))
                0: v[3:0] = 4'd0;
                1: v[3:0] = 4'($urandom_range(15, 9));
                default: v[3:0] = 4'($urandom_range(8, 1));
            endcase
            if (flood) v[3:0] = 4'($urandom_range(8, 1));
            write_reg(CFG_PATTERN_LENGTH, v);
        end
        v = {$urandom, $urandom};
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(5))
                0: v[31:0] = 32'h0;
                1: v[31:0] = 32'hFFFF_FFFF - $urandom_range(20);
                default: ;
            endcase
            write_reg(CFG_BASE_ADDRESS, v);
        end
        v = {$urandom, $urandom};
        if (flood || $urandom_range(99) < 60) begin
            case ($urandom_range(7))
                0: v[15:0] = 16'd0;
                1: v[15:0] = 16'hFFFF;
                2, 3: v[15:0] = 16'($urandom_range(3, 1));
                default: v[15:0] = 16'($urandom_range(16'hFFFF, 1));
            endcase
            if (flood) v[15:0] = 16'hFFFF;
            write_reg(CFG_MAX_MATCHES, v);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // planted copies of the pattern (wildcards filled at random), mixed
    // with near misses and noise
    task automatic send_scan(input int count, input int plant_pct);
        logic [7:0] queued [$];
        logic [7:0] b;
        int len;
        int pick;
        len = (sb.pat_len == 0 || sb.pat_len > 8) ? 8 : sb.pat_len;
        for (int k = 0; k < count; k++) begin
            if (queued.size() == 0 && $urandom_range(99) < plant_pct) begin
                for (int j = 0; j < len; j++) begin
                    b = sb.pattern[8*j +: 8];
                    if (!sb.care[j] || $urandom_range(19) == 0) b = 8'($urandom_range(255));
                    queued.insert(queued.size(), b);
                end
            end
            if (queued.size() != 0) begin
                b = queued.pop_front();
            end else if ($urandom_range(1)) begin
                b = 8'($urandom_range(255));
            end else begin
                pick = $urandom_range(7);
                b = sb.pattern[8*pick +: 8];
            end
            no_idle = (random_items >= 250 && random_items < 380);
            send_byte(b, k == count - 1);
            random_items++;
        end
    endtask

    initial begin
        int phase;
        int scans;
        int scan_len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: single zero byte pattern
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        i_in_valid <= 1'b0;
        wait_drained();

        // all wildcards, too few bytes at first, limit of two, address wrap
        write_reg(CFG_PATTERN_BYTES, 64'h8877_6655_4433_2211);
        write_reg(CFG_CARE_MASK, 64'h0);
        write_reg(CFG_PATTERN_LENGTH, 64'd4);
        write_reg(CFG_BASE_ADDRESS, 64'hFFFF_FFFF);
        write_reg(CFG_MAX_MATCHES, 64'd2);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 6; k++) send_byte(8'($urandom_range(255)), k == 5);
        i_in_valid <= 1'b0;
        wait_drained();

        // oversize length clamps to eight; zero limit still reports once
        write_reg(CFG_PATTERN_LENGTH, 64'd15);
        write_reg(CFG_MAX_MATCHES, 64'd0);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 9; k++) send_byte(8'($urandom_range(255)), k == 8);
        i_in_valid <= 1'b0;
        wait_drained();

        // zero length never matches
        write_reg(CFG_PATTERN_LENGTH, 64'd0);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 3; k++) send_byte(8'($urandom_range(255)), k == 2);
        i_in_valid <= 1'b0;

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_drained();
            set_up_phase(phase == 4);
            // every full window matches here, so the hold-off backs up the input
            if (phase == 4) stall_request = 1'b1;
            scans = $urandom_range(4, 2);
            for (int s = 0; s < scans; s++) begin
                if (phase == 4)
                    scan_len = 90;
                else if ($urandom_range(9) == 0)
                    scan_len = $urandom_range(100, 40);
                else
                    scan_len = $urandom_range(30, 1);
                send_scan(scan_len, $urandom_range(80, 20));
            end
            i_in_valid <= 1'b0;
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/mbps_out_buf.sv
rtl/masked_byte_pattern_search_top.sv
rtl/mbps_checker.sv
verif/testbench.sv
